@@ src/nflp_pkg.sv @@
// Package for the numeric for-loop prepare block: word size, status codes,
// queue entry and queue status types, a shared helper (sext). No dependencies.
package nflp_pkg;

   localparam int WORD_BITS = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [63:0] MAX_INT = {1'b0, {63{1'b1}}} >> (64 - WORD_BITS);
   localparam logic [63:0] MIN_INT = ~MAX_INT;
   localparam logic [63:0] HALF_RANGE = MAX_INT + 64'd1;

   typedef enum logic [1:0] {
      ST_RUN       = 2'd0,
      ST_SKIP      = 2'd1,
      ST_ZERO_STEP = 2'd2
   } status_type;

   typedef struct packed {
      logic [63:0] init;
      logic [63:0] lim;
      logic [63:0] step;
      logic        zero_step;
      logic        skip;
      logic        step_neg;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Take the low WORD_BITS bits and sign-extend them to 64.
   function automatic logic [63:0] sext(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) begin
         r[i] = (i < WORD_BITS) ? v[i] : v[WORD_BITS-1];
      end
      return r;
   endfunction

endpackage

@@ src/nflp_front.sv @@
// Front part: classifies one loop request and converts a double limit.
// Depends on nflp_pkg.
module nflp_front (
   input  logic signed [63:0] init_value,
   input  logic signed [63:0] step_value,
   input  logic signed [63:0] limit_integer,
   input  logic        [63:0] limit_double_bits,
   input  logic               limit_is_double,
   output nflp_pkg::entry_type entry
);

   always_comb begin
      logic [63:0] step_s;
      logic        step_neg;
      logic        neg;
      logic [10:0] e;
      logic [51:0] frac;
      logic [52:0] sig;
      logic        too_big;
      logic [63:0] mag;
      logic [10:0] sh;
      logic [10:0] r;
      logic [63:0] ip;
      logic        fr;
      logic        dbl_skip;
      logic [63:0] dbl_lim;

      step_s   = nflp_pkg::sext(step_value);
      step_neg = step_s[63];
      neg      = limit_double_bits[63];
      e        = limit_double_bits[62:52];
      frac     = limit_double_bits[51:0];
      sig      = (e == 11'd0) ? {1'b0, frac} : {1'b1, frac};
      too_big  = 1'b0;
      mag      = 64'd0;
      sh       = 11'd0;
      r        = 11'd0;
      ip       = 64'd0;
      fr       = 1'b0;

      if (e == 11'h7FF) begin
         // NaN acts as a negative value below range
         if (frac != 52'd0) neg = 1'b1;
         too_big = 1'b1;
      end else begin
         if (e >= 11'd1075) begin
            sh = e - 11'd1075;
            if (sh > 11'd11 || sig == 53'd0) begin
               too_big = (sig != 53'd0);
            end else begin
               mag = {11'd0, sig} << sh[3:0];
            end
         end else begin
            r = (e == 11'd0) ? 11'd1074 : (11'd1075 - e);
            if (r >= 11'd64) begin
               ip = 64'd0;
               fr = (sig != 53'd0);
            end else begin
               ip = {11'd0, sig} >> r[5:0];
               fr = (({11'd0, sig} & ((64'd1 << r[5:0]) - 64'd1)) != 64'd0);
            end
            // floor for a positive step, ceiling for a negative one
            if (fr && (neg != step_neg)) ip = ip + 64'd1;
            mag = ip;
         end
         too_big = too_big ||
                   (neg ? (mag > nflp_pkg::HALF_RANGE) : (mag > nflp_pkg::MAX_INT));
      end

      dbl_skip = 1'b0;
      if (too_big) begin
         dbl_skip = (neg != step_neg);
         dbl_lim  = neg ? nflp_pkg::MIN_INT : nflp_pkg::MAX_INT;
      end else begin
         dbl_lim  = nflp_pkg::sext(neg ? (64'd0 - mag) : mag);
      end

      entry.init      = nflp_pkg::sext(init_value);
      entry.step      = step_s;
      entry.step_neg  = step_neg;
      entry.zero_step = (step_s == 64'd0);
      entry.lim       = limit_is_double ? dbl_lim : nflp_pkg::sext(limit_integer);
      entry.skip      = limit_is_double && dbl_skip;
   end

endmodule

@@ src/nflp_queue.sv @@
// Short queue between the front and back parts.
// Depends on nflp_pkg.
module nflp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  nflp_pkg::entry_type          push_data,
   input  logic                         pop,
   output nflp_pkg::entry_type          head,
   output nflp_pkg::queue_status_type   status
);

   nflp_pkg::entry_type mem_ff [nflp_pkg::QUEUE_DEPTH];
   logic [nflp_pkg::QUEUE_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [nflp_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (nflp_pkg::QUEUE_PTR_BITS+1)'(nflp_pkg::QUEUE_DEPTH));
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (nflp_pkg::QUEUE_PTR_BITS+1)'(do_push)
                          - (nflp_pkg::QUEUE_PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

@@ src/nflp_back.sv @@
// Back part: range check, span and divisor, then a pipelined restoring
// divider with one quotient bit per stage. Depends on nflp_pkg.
module nflp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  nflp_pkg::entry_type        head,
   input  logic                       head_valid,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [63:0]                rsp_iteration_count
);

   localparam int W = nflp_pkg::WORD_BITS;

   logic [W:0]   valid_ff;
   logic [1:0]   stat_ff [W+1];
   logic [W-1:0] rem_ff  [W+1];
   logic [W-1:0] quo_ff  [W+1];
   logic [W-1:0] div_ff  [W+1];
   logic [W-1:0] rem_in  [W+1];
   logic [W-1:0] quo_in  [W+1];
   logic [1:0]   stat0_in;
   logic [W-1:0] span0_in, div0_in;
   logic         advance;

   assign advance = !valid_ff[W] || !rsp_stall;
   assign pop = advance && head_valid;

   always_comb begin
      logic        late_skip;
      logic [63:0] diff;
      logic [63:0] mag;
      late_skip = head.step_neg ? ($signed(head.init) < $signed(head.lim))
                                : ($signed(head.lim) < $signed(head.init));
      diff = head.step_neg ? head.init - head.lim : head.lim - head.init;
      mag  = head.step_neg ? 64'd0 - head.step : head.step;
      span0_in = diff[W-1:0];
      div0_in  = mag[W-1:0];
      if (head.zero_step) stat0_in = nflp_pkg::ST_ZERO_STEP;
      else if (head.skip || late_skip) stat0_in = nflp_pkg::ST_SKIP;
      else stat0_in = nflp_pkg::ST_RUN;
   end

   // one restoring step per stage
   always_comb begin
      rem_in[0] = '0;
      quo_in[0] = '0;
      for (int k = 1; k <= W; k++) begin
         logic [W:0] trial;
         trial = {rem_ff[k-1], quo_ff[k-1][W-1]} - {1'b0, div_ff[k-1]};
         rem_in[k] = trial[W] ? {rem_ff[k-1][W-2:0], quo_ff[k-1][W-1]} : trial[W-1:0];
         quo_in[k] = {quo_ff[k-1][W-2:0], ~trial[W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[W-1:0], head_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stat_ff[0] <= stat0_in;
         rem_ff[0]  <= '0;
         quo_ff[0]  <= span0_in;
         div_ff[0]  <= div0_in;
         for (int k = 1; k <= W; k++) begin
            stat_ff[k] <= stat_ff[k-1];
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            div_ff[k]  <= div_ff[k-1];
         end
      end
   end

   assign rsp_valid  = valid_ff[W];
   assign rsp_status = stat_ff[W];
   assign rsp_iteration_count = (stat_ff[W] == nflp_pkg::ST_RUN) ? 64'(quo_ff[W]) : 64'd0;

endmodule

@@ src/numeric_for_loop_prepare_top.sv @@
// Top level of the numeric for-loop prepare block.
// Depends on nflp_pkg, nflp_front, nflp_queue, nflp_back.

// Prepares one integer for-loop per transfer: init, step and a limit given
// as an integer or as double bits. It answers with a status (run, skip,
// zero step) and the count of iterations after the first. A new request
// is taken every cycle while the queue is not full. Each request is
// registered in the queue, then in the divider's setup stage, then in
// the divider stages, one pipeline stage per quotient bit, before its
// result is presented. A four-entry queue sits between the classifying
// front and the divider back, so a stalled result holds the back while
// the front keeps taking requests until the queue fills.
module numeric_for_loop_prepare_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [63:0] req_init_value,
   input  logic signed [63:0] req_step_value,
   input  logic signed [63:0] req_limit_integer,
   input  logic        [63:0] req_limit_double_bits,
   input  logic               req_limit_is_double,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [63:0]        rsp_iteration_count
);

   nflp_pkg::entry_type        entry;
   nflp_pkg::entry_type        head;
   nflp_pkg::queue_status_type q_status;
   logic                       pop;

   // classify the request and convert a double limit
   nflp_front u_front (
      .init_value        (req_init_value),
      .step_value        (req_step_value),
      .limit_integer     (req_limit_integer),
      .limit_double_bits (req_limit_double_bits),
      .limit_is_double   (req_limit_is_double),
      .entry             (entry)
   );

   // hold classified requests until the back is free
   assign req_stall = q_status.full;

   nflp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (entry),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // advance the divider pipeline whenever the result slot frees up
   nflp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .head_valid          (!q_status.empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_iteration_count (rsp_iteration_count)
   );

   a_count_zero_unless_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != nflp_pkg::ST_RUN |-> rsp_iteration_count == 64'd0)
      else $error("count not zero on a non-run result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == nflp_pkg::ST_RUN || rsp_status == nflp_pkg::ST_SKIP ||
                     rsp_status == nflp_pkg::ST_ZERO_STEP))
      else $error("result status code undefined");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("pop from empty queue");

endmodule
